/* rtl/core/sscs_pkg.sv */
`default_nettype none
package sscs_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int FIXED_WORDS = 4;
  localparam int STORE_SIZE = FIXED_WORDS + DIGIT_COUNT;
  localparam int SLOT_W = $clog2(STORE_SIZE);
  localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam logic [SLOT_W-1:0] SLOT_SCANLIMIT = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_DECODE = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_INTENSITY = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_WAKEUP = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_DIGIT0 = SLOT_W'(FIXED_WORDS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(STORE_SIZE - 1);

  localparam logic [3:0] ADDR_DECODE = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [3:0] ADDR_SCANLIMIT = 4'hB;
  localparam logic [3:0] ADDR_WAKEUP = 4'hC;

  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_DECIMAL = 3'd1;
  localparam logic [2:0] OP_HEX = 3'd2;
  localparam logic [2:0] OP_POINTS = 3'd3;
  localparam logic [2:0] OP_INTENSITY = 3'd4;
  localparam logic [2:0] OP_WAKEUP = 3'd5;
  localparam logic [2:0] OP_UPDATE = 3'd6;

  localparam logic [15:0] POINT_MASK = 16'hFF7F;
  localparam logic [16:0] RECIP_TEN = 17'd52429;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIMAL,
    ST_HEX,
    ST_POINTS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] value;
    logic [1:0]  min_digits;
  } in_item_t;

  typedef struct packed {
    logic [15:0] command_word;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [15:0] word;
    logic [15:0] x_nxt;
    logic        blank_nxt;
  } step_t;

  function automatic logic [15:0] make_word(logic [3:0] addr, logic [7:0] data);
    return {4'h0, addr, data};
  endfunction

  function automatic logic [7:0] seg_code(logic [3:0] nib);
    logic [7:0] s;
    unique case (nib)
      4'h0: s = 8'h7E;
      4'h1: s = 8'h30;
      4'h2: s = 8'h6D;
      4'h3: s = 8'h79;
      4'h4: s = 8'h33;
      4'h5: s = 8'h5B;
      4'h6: s = 8'h5F;
      4'h7: s = 8'h70;
      4'h8: s = 8'h7F;
      4'h9: s = 8'h7B;
      4'hA: s = 8'h77;
      4'hB: s = 8'h1F;
      4'hC: s = 8'h4E;
      4'hD: s = 8'h3D;
      4'hE: s = 8'h4F;
      4'hF: s = 8'h47;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] power_up_digit(logic [1:0] k);
    logic [7:0] p;
    unique case (k)
      2'd0: p = 8'h55;
      2'd1: p = 8'hAA;
      2'd2: p = 8'h00;
      2'd3: p = 8'hFF;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/seven_segment_command_shadow.sv */
// Seven-segment command shadow: keeps eight display-driver command words
// (scan limit, decode mode, intensity, wakeup, four digits) and a dirty flag.
// Input channel in_valid/in_ready/in_data carries one command per transaction;
// output channel out_valid/out_ready/out_data carries emitted command words,
// with last_word set on the final word of each run.
// What each command does before in_ready returns:
//   intensity, wakeup, unused opcode, clean update: no busy state; in_ready stays high.
//   decimal, hex, decimal points: one digit word per cycle through the shared
//   divide-by-ten / shift step unit, DIGIT_COUNT digit words in all.
//   init: all eight store words, update when dirty: the six from intensity on,
//   one store read per cycle into the output register while the receiver does not stall.
// The accepting edge puts the sequencer in its emit state, which then loads the first word into the output register. A
// stalled receiver holds the emitting sequencer; the final word sits in the
// output register while the block is already ready for the next command.
// Reset (rst_n low, synchronous) loads the power-up command words, clears the
// dirty flag and drops any pending output word.
`default_nettype none
module seven_segment_command_shadow
  import sscs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [15:0]         x_r, x_nxt;
  logic [1:0]          min_r, min_nxt;
  logic                blank_r, blank_nxt;
  logic                changed_r, changed_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic [15:0]         store_r [STORE_SIZE];

  logic                wr_en;
  logic [SLOT_W-1:0]   wr_slot;
  logic [15:0]         wr_word;
  logic [SLOT_W-1:0]   digit_slot;
  step_t               step;
  logic                in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign digit_slot = slot_r - SLOT_DIGIT0;

  sscs_step_unit u_step (
    .state      (state_r),
    .x          (x_r),
    .cur_word   (store_r[slot_r]),
    .digit_idx  (digit_slot[DIG_W-1:0]),
    .min_digits (min_r),
    .blank      (blank_r),
    .step       (step)
  );

  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r;
    x_nxt = x_r;
    min_nxt = min_r;
    blank_nxt = blank_r;
    changed_nxt = changed_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    wr_en = 1'b0;
    wr_slot = slot_r;
    wr_word = step.word;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt = in_data.value;
          min_nxt = in_data.min_digits;
          blank_nxt = 1'b0;
          slot_nxt = SLOT_DIGIT0;
          priority case (in_data.opcode)
            OP_INIT: begin
              changed_nxt = 1'b0;
              slot_nxt = SLOT_SCANLIMIT;
              state_nxt = ST_EMIT;
            end
            OP_DECIMAL: state_nxt = ST_DECIMAL;
            OP_HEX: state_nxt = ST_HEX;
            OP_POINTS: state_nxt = ST_POINTS;
            OP_INTENSITY: begin
              wr_en = 1'b1;
              wr_slot = SLOT_INTENSITY;
              wr_word = make_word(ADDR_INTENSITY, {4'h0, in_data.value[3:0]});
            end
            OP_WAKEUP: begin
              wr_en = 1'b1;
              wr_slot = SLOT_WAKEUP;
              wr_word = make_word(ADDR_WAKEUP, {7'h00, in_data.value[0]});
            end
            OP_UPDATE: begin
              if (changed_r) begin
                changed_nxt = 1'b0;
                slot_nxt = SLOT_INTENSITY;
                state_nxt = ST_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DECIMAL, ST_HEX, ST_POINTS: begin
        wr_en = 1'b1;
        x_nxt = step.x_nxt;
        blank_nxt = step.blank_nxt;
        if (slot_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      ST_EMIT: begin
        // load the next word once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.command_word = store_r[slot_r];
          out_data_nxt.last_word = (slot_r == SLOT_LAST);
          if (slot_r == SLOT_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (wr_en && (store_r[wr_slot] != wr_word)) begin
      changed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      changed_r <= 1'b0;
      out_valid_r <= 1'b0;
      slot_r <= '0;
      blank_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      changed_r <= changed_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r <= slot_nxt;
      blank_r <= blank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    min_r <= min_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r[SLOT_SCANLIMIT] <= make_word(ADDR_SCANLIMIT, 8'(DIGIT_COUNT - 1));
      store_r[SLOT_DECODE] <= make_word(ADDR_DECODE, 8'h00);
      store_r[SLOT_INTENSITY] <= make_word(ADDR_INTENSITY, 8'h0F);
      store_r[SLOT_WAKEUP] <= make_word(ADDR_WAKEUP, 8'h01);
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        store_r[FIXED_WORDS + i] <= make_word(4'(i + 1), power_up_digit(2'(i)));
      end
    end else if (wr_en && (store_r[wr_slot] != wr_word)) begin
      store_r[wr_slot] <= wr_word;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sscs_step_unit.sv */
`default_nettype none
module sscs_step_unit
  import sscs_pkg::*;
(
  input  state_t            state,
  input  logic [15:0]       x,
  input  logic [15:0]       cur_word,
  input  logic [DIG_W-1:0]  digit_idx,
  input  logic [1:0]        min_digits,
  input  logic              blank,
  output step_t             step
);

  logic [32:0] prod;
  logic [15:0] quot;
  logic [15:0] quot_ten;
  logic [15:0] rem_full;
  logic [3:0]  rem;
  logic [3:0]  addr;
  logic        at_min;

  // divide by ten through the reciprocal, exact for any 16-bit value
  assign prod = {1'b0, x} * {16'h0, RECIP_TEN};
  assign quot = {2'b00, prod[32:19]};
  assign quot_ten = (quot << 3) + (quot << 1);
  assign rem_full = x - quot_ten;
  assign rem = rem_full[3:0];
  assign addr = 4'(digit_idx) + 4'd1;
  assign at_min = 4'(digit_idx) >= 4'(min_digits);

  always_comb begin
    step = '0;
    unique case (state)
      ST_DECIMAL: begin
        if (blank) begin
          step.word = make_word(addr, 8'h00);
          step.x_nxt = x;
          step.blank_nxt = 1'b1;
        end else begin
          step.word = make_word(addr, seg_code(rem));
          step.x_nxt = quot;
          step.blank_nxt = (quot == 16'h0) && at_min;
        end
      end
      ST_HEX: begin
        step.word = make_word(addr, seg_code(x[3:0]));
        step.x_nxt = x >> 4;
        step.blank_nxt = blank;
      end
      ST_POINTS: begin
        step.word = (cur_word & POINT_MASK) | {8'h00, x[0], 7'h00};
        step.x_nxt = x >> 1;
        step.blank_nxt = blank;
      end
      default: begin
        step.word = cur_word;
        step.x_nxt = x;
        step.blank_nxt = blank;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/sscs_checker.sv */
`default_nettype none
module sscs_checker
  import sscs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // a non-final word in flight means the run is still being emitted
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_word |-> !in_ready)
    else $error("ready while an emitted run is incomplete");

  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_INIT) |=> !in_ready)
    else $error("ready right after an init transaction");

  a_digit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.opcode == OP_DECIMAL || in_data.opcode == OP_HEX ||
     in_data.opcode == OP_POINTS) |=> !in_ready)
    else $error("ready right after a digit transaction");

endmodule

bind seven_segment_command_shadow sscs_checker u_sscs_checker (.*);
`default_nettype wire

/* bench/seven_segment_command_shadow_tb.sv */
`timescale 1ns / 1ps
module seven_segment_command_shadow_tb;
  import sscs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_PER_PHASE = 26;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RESET_CYCLES = 11;

  localparam logic [7:0] SEG_CODES [16] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
  };
  localparam logic [7:0] DIGIT_PATTERN [4] = '{8'h55, 8'hAA, 8'h00, 8'hFF};

  // per phase: percent of cycles the sender idles and the receiver stalls
  localparam int SEND_IDLE [4] = '{0, 70, 0, 11};
  localparam int RECV_STALL [4] = '{0, 0, 70, 11};

  // typed_words lists the expected run first-out first, starting at index 7
  typedef struct packed {
    in_item_t         cmd;
    logic             typed;
    logic [3:0]       typed_count;
    logic [7:0][15:0] typed_words;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [15:0] shadow_store [STORE_SIZE];
  logic        shadow_dirty;
  logic [15:0] run_words [STORE_SIZE];
  int          run_len;
  out_item_t   pending_words [$];
  out_item_t   oldest_word;

  int stall_pct = 0;
  int error_count = 0;
  int words_checked = 0;
  int runs_seen = 0;
  int commands_sent = 0;
  int quiet_cycles = 0;

  seven_segment_command_shadow u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic void store_word(int slot, logic [15:0] w);
    if (shadow_store[slot] != w) begin
      shadow_store[slot] = w;
      shadow_dirty = 1'b1;
    end
  endfunction

  function automatic void emit_store(int first);
    for (int s = first; s < STORE_SIZE; s++) begin
      run_words[run_len] = shadow_store[s];
      run_len++;
    end
    shadow_dirty = 1'b0;
  endfunction

  function automatic void shadow_reset();
    shadow_store[SLOT_SCANLIMIT] = {4'h0, ADDR_SCANLIMIT, 8'(DIGIT_COUNT - 1)};
    shadow_store[SLOT_DECODE] = {4'h0, ADDR_DECODE, 8'h00};
    shadow_store[SLOT_INTENSITY] = {4'h0, ADDR_INTENSITY, 8'h0F};
    shadow_store[SLOT_WAKEUP] = {4'h0, ADDR_WAKEUP, 8'h01};
    for (int i = 0; i < DIGIT_COUNT; i++)
      shadow_store[int'(SLOT_DIGIT0) + i] = {4'h0, 4'(i + 1), DIGIT_PATTERN[i % 4]};
    shadow_dirty = 1'b0;
    run_len = 0;
  endfunction

  // Update the shadow copy for one command; leave the emitted words in run_words.
  function automatic void shadow_apply(in_item_t cmd);
    int unsigned rest;
    int          top;
    logic [3:0]  nib;
    logic [15:0] word;
    run_len = 0;
    case (cmd.opcode)
      OP_INIT: emit_store(0);
      OP_DECIMAL: begin
        rest = cmd.value;
        top = DIGIT_COUNT - 1;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          if (i <= top) begin
            store_word(int'(SLOT_DIGIT0) + i, {4'h0, 4'(i + 1), SEG_CODES[rest % 10]});
            rest = rest / 10;
            // blank everything above the first zero quotient past the minimum
            if (rest == 0 && i >= int'(cmd.min_digits))
              top = i;
          end else begin
            store_word(int'(SLOT_DIGIT0) + i, {4'h0, 4'(i + 1), 8'h00});
          end
        end
      end
      OP_HEX: begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          nib = (i < 4) ? cmd.value[4*i +: 4] : 4'h0;
          store_word(int'(SLOT_DIGIT0) + i, {4'h0, 4'(i + 1), SEG_CODES[nib]});
        end
      end
      OP_POINTS: begin
        for (int i = 0; i < DIGIT_COUNT && i < 16; i++) begin
          word = (shadow_store[int'(SLOT_DIGIT0) + i] & POINT_MASK)
                 | {8'h00, cmd.value[i], 7'h00};
          store_word(int'(SLOT_DIGIT0) + i, word);
        end
      end
      OP_INTENSITY: store_word(SLOT_INTENSITY, {4'h0, ADDR_INTENSITY, 4'h0, cmd.value[3:0]});
      OP_WAKEUP: store_word(SLOT_WAKEUP, {4'h0, ADDR_WAKEUP, 7'h00, cmd.value[0]});
      OP_UPDATE: if (shadow_dirty) emit_store(SLOT_INTENSITY);
      default: ;
    endcase
  endfunction

  function automatic void queue_run();
    out_item_t w;
    for (int k = 0; k < run_len; k++) begin
      w.command_word = run_words[k];
      w.last_word = (k == run_len - 1);
      pending_words.push_back(w);
    end
  endfunction

  function automatic script_row_t script_row(logic [2:0] op, logic [15:0] val,
                                             logic [1:0] min_digits, logic typed,
                                             logic [3:0] count,
                                             logic [7:0][15:0] words);
    script_row_t row;
    row.cmd.opcode = op;
    row.cmd.value = val;
    row.cmd.min_digits = min_digits;
    row.typed = typed;
    row.typed_count = count;
    row.typed_words = words;
    return row;
  endfunction

  function automatic in_item_t random_command();
    in_item_t cmd;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) cmd.opcode = OP_INIT;
    else if (pick < 30) cmd.opcode = OP_DECIMAL;
    else if (pick < 44) cmd.opcode = OP_HEX;
    else if (pick < 56) cmd.opcode = OP_POINTS;
    else if (pick < 66) cmd.opcode = OP_INTENSITY;
    else if (pick < 74) cmd.opcode = OP_WAKEUP;
    else if (pick < 97) cmd.opcode = OP_UPDATE;
    else cmd.opcode = OP_UNUSED;
    // small values exercise leading-zero blanking
    if ($urandom_range(0, 1) == 0)
      cmd.value = 16'($urandom_range(0, 150));
    else
      cmd.value = 16'($urandom());
    cmd.min_digits = 2'($urandom_range(0, 3));
    return cmd;
  endfunction

  task automatic send_command(input in_item_t cmd, input int idle_pct);
    while ($urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk)
    out_ready <= ($urandom_range(1, 100) > stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (out_data.last_word) runs_seen++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected transaction, word %h last %b",
                 $time, out_data.command_word, out_data.last_word);
        error_count++;
      end else begin
        oldest_word = pending_words.pop_front();
        if (out_data.command_word !== oldest_word.command_word) begin
          $display("%0t: command_word expected %h actual %h",
                   $time, oldest_word.command_word, out_data.command_word);
          error_count++;
        end
        if (out_data.last_word !== oldest_word.last_word) begin
          $display("%0t: last_word expected %b actual %b",
                   $time, oldest_word.last_word, out_data.last_word);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d words outstanding",
               $time, WATCHDOG_LIMIT, pending_words.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    script_row_t script [$];
    in_item_t    cmd;
    shadow_reset();

    script.push_back(script_row(OP_INIT, 16'h0000, 2'd0, 1'b1, 4'd8,
      {16'h0B03, 16'h0900, 16'h0A0F, 16'h0C01, 16'h0155, 16'h02AA, 16'h0300, 16'h04FF}));
    script.push_back(script_row(OP_UPDATE, 16'h0000, 2'd0, 1'b1, 4'd0, '0));
    script.push_back(script_row(OP_UNUSED, 16'hFFFF, 2'd3, 1'b1, 4'd0, '0));
    // intensity is already at maximum, so the store stays clean
    script.push_back(script_row(OP_INTENSITY, 16'hFFFF, 2'd3, 1'b1, 4'd0, '0));
    script.push_back(script_row(OP_UPDATE, 16'hFFFF, 2'd3, 1'b1, 4'd0, '0));
    script.push_back(script_row(OP_INTENSITY, 16'h0000, 2'd0, 1'b1, 4'd0, '0));
    script.push_back(script_row(OP_UPDATE, 16'h0000, 2'd0, 1'b1, 4'd6,
      {16'h0A00, 16'h0C01, 16'h0155, 16'h02AA, 16'h0300, 16'h04FF, 32'h0}));
    script.push_back(script_row(OP_WAKEUP, 16'hFFFE, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_DECIMAL, 16'd0, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_DECIMAL, 16'd0, 2'd3, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_DECIMAL, 16'hFFFF, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_DECIMAL, 16'd9999, 2'd1, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_DECIMAL, 16'd7, 2'd2, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_UPDATE, 16'h0000, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_HEX, 16'hFFFF, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_HEX, 16'h0000, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_HEX, 16'h89AB, 2'd2, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_POINTS, 16'hFFFF, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_UPDATE, 16'h0000, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_POINTS, 16'h000A, 2'd1, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_POINTS, 16'h0000, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_WAKEUP, 16'h0001, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_INIT, 16'h0000, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_DECIMAL, 16'd12345, 2'd0, 1'b0, 4'd0, '0));
    script.push_back(script_row(OP_UPDATE, 16'h0000, 2'd0, 1'b0, 4'd0, '0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      send_command(script[r].cmd, 0);
      shadow_apply(script[r].cmd);
      if (script[r].typed) begin
        run_len = script[r].typed_count;
        for (int k = 0; k < run_len; k++)
          run_words[k] = script[r].typed_words[7 - k];
      end
      queue_run();
      commands_sent++;
    end

    for (int ph = 0; ph < 4; ph++) begin
      // hold the sender until every outstanding word has drained
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_words.size() != 0);
      stall_pct = RECV_STALL[ph];
      repeat (RANDOM_PER_PHASE) begin
        cmd = random_command();
        send_command(cmd, SEND_IDLE[ph]);
        shadow_apply(cmd);
        queue_run();
        commands_sent++;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands (%0d from the directed table) under four idle/stall mixes",
             commands_sent, script.size());
    $display("checked %0d command words in %0d emitted runs", words_checked, runs_seen);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
